// ===== src/tdpf_pkg.sv =====
// Shared widths and constants for the trial-division prime filter.
package tdpf_pkg;

  // Fixed widths of the channel fields.
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 32;

  // Widest internal value the test can be configured for.
  localparam int MAX_BITS = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Trial division starts at this divisor.
  localparam int FIRST_DIVISOR = 2;

endpackage

// ===== src/tdpf_if.sv =====
// Request and result channels of the trial-division prime filter.
interface tdpf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [tdpf_pkg::DATA_W-1:0] value;
  logic                              last_of_list;

  modport source (output valid, output value, output last_of_list, input ready);
  modport sink   (input valid, input value, input last_of_list, output ready);
endinterface

interface tdpf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tdpf_pkg::DATA_W-1:0]  value_out;
  logic                               is_prime;
  logic        [tdpf_pkg::COUNT_W-1:0] prime_count;
  logic                               end_of_list;

  modport source (output valid, output value_out, output is_prime, output prime_count,
                  output end_of_list, input ready);
  modport sink   (input valid, input value_out, input is_prime, input prime_count,
                  input end_of_list, output ready);
endinterface

// ===== src/trial_division_prime_filter_core.sv =====
// Values below two and negative values go from the idle state straight to the done state.
// Other values run one restoring division over VALUE_BITS bits and one check per divisor
// tried, from 2 up to floor(sqrt(n))+1 for a prime. One request is in work at a time;
// the single shared subtract unit sets the rate. A finished result waits in the output
// register while the next request is taken. Synchronous active-low reset clears the
// sequencer, count, out valid.
module trial_division_prime_filter_core #(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  tdpf_in_if.sink    in_chan,
  tdpf_out_if.source out_chan
);

  localparam int W     = VALUE_BITS;
  localparam int CNT_W = $clog2(VALUE_BITS);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_CHECK, ST_DONE} state_t;

  state_t                              state_r;
  logic   [W-1:0]                      num_r;
  logic   [W-1:0]                      div_r;
  logic   [W-1:0]                      quo_r;
  logic   [W-1:0]                      rem_r;
  logic   [CNT_W-1:0]                  bit_cnt_r;
  logic                                prime_r;
  logic                                last_r;
  logic   [tdpf_pkg::DATA_W-1:0]       val_r;
  logic   [tdpf_pkg::COUNT_W-1:0]      cnt_r;

  logic                                out_valid_r;
  logic   [tdpf_pkg::DATA_W-1:0]       out_value_r;
  logic                                out_prime_r;
  logic   [tdpf_pkg::COUNT_W-1:0]      out_count_r;
  logic                                out_last_r;

  logic   [tdpf_pkg::MAX_BITS-1:0]     in_ext;
  logic   [W-1:0]                      in_num;
  logic   [tdpf_pkg::MAX_BITS-1:0]     in_sx;
  logic   [W:0]                        rem_sh;
  logic   [W:0]                        diff;
  logic                                q_bit;
  logic   [tdpf_pkg::COUNT_W-1:0]      cnt_inc;
  logic                                load_out;

  // Only the low VALUE_BITS bits of the request take part.
  assign in_ext = tdpf_pkg::MAX_BITS'(unsigned'(in_chan.value));
  assign in_num = in_ext[W-1:0];
  assign in_sx  = tdpf_pkg::MAX_BITS'(signed'(in_num));

  // One restoring division step: shift in the next dividend bit, try a subtract.
  assign rem_sh = {rem_r, quo_r[W-1]};
  assign diff   = rem_sh - {1'b0, div_r};
  assign q_bit  = ~diff[W];

  assign cnt_inc  = (prime_r && (cnt_r != tdpf_pkg::COUNT_MAX)) ? cnt_r + 1'b1 : cnt_r;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.value_out   = signed'(out_value_r);
  assign out_chan.is_prime    = out_prime_r;
  assign out_chan.prime_count = out_count_r;
  assign out_chan.end_of_list = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_chan.valid) begin
            num_r     <= in_num;
            val_r     <= in_sx[tdpf_pkg::DATA_W-1:0];
            last_r    <= in_chan.last_of_list;
            div_r     <= W'(tdpf_pkg::FIRST_DIVISOR);
            quo_r     <= in_num;
            rem_r     <= '0;
            bit_cnt_r <= CNT_W'(W - 1);
            prime_r   <= 1'b0;
            // Negative values and values below two are not prime.
            if (in_num[W-1] || (in_num < W'(tdpf_pkg::FIRST_DIVISOR))) begin
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem_r     <= q_bit ? diff[W-1:0] : rem_sh[W-1:0];
          quo_r     <= {quo_r[W-2:0], q_bit};
          bit_cnt_r <= bit_cnt_r - 1'b1;
          if (bit_cnt_r == '0) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          // Once the divisor exceeds the quotient it has passed the square root.
          priority if (div_r > quo_r) begin
            prime_r <= 1'b1;
            state_r <= ST_DONE;
          end else if (rem_r == '0) begin
            prime_r <= 1'b0;
            state_r <= ST_DONE;
          end else begin
            div_r     <= div_r + 1'b1;
            quo_r     <= num_r;
            rem_r     <= '0;
            bit_cnt_r <= CNT_W'(W - 1);
            state_r   <= ST_DIV;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_value_r <= val_r;
            out_prime_r <= prime_r;
            out_count_r <= cnt_inc;
            out_last_r  <= last_r;
            cnt_r       <= last_r ? '0 : cnt_inc;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // A request keeps the unit busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("ready stayed high after a request was taken");

  // Trial divisors never drop below the first divisor.
  a_divisor_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_r >= W'(tdpf_pkg::FIRST_DIVISOR)))
    else $error("divisor below two during division");

  // A prime result is a positive value and has been counted.
  a_prime_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_prime_r) |-> (!out_value_r[tdpf_pkg::DATA_W-1] && (out_count_r != '0)))
    else $error("prime result with negative value or zero count");

  // The running count restarts after the end of a list.
  a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && last_r) |=> (cnt_r == '0))
    else $error("count not cleared after end of list");

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the trial-division prime filter: random and directed lists, scoreboard check.
`timescale 1ns / 1ps

module tb_top;

  localparam int       VALUE_BITS = 32;
  localparam int       CLK_HALF   = 10;
  localparam longint   LIMIT_NS   = 64'd1_000_000_000;
  localparam int       RAND_ITEMS = 400;
  localparam int       LONG_HOLD  = 400;

  typedef logic signed [tdpf_pkg::DATA_W-1:0] value_t;
  typedef logic        [tdpf_pkg::COUNT_W-1:0] count_t;

  typedef struct {
    value_t value;
    bit     is_prime;
    count_t prime_count;
    bit     end_of_list;
  } prime_verdict_t;

  // Holds the running prime count of the open list and the verdicts still owed.
  class prime_tally_board;
    prime_verdict_t owed_q[$];
    count_t         list_primes;
    int unsigned    mismatches;
    int unsigned    requests;
    int unsigned    primes_seen;
    int unsigned    lists_closed;

    function new();
      list_primes  = '0;
      mismatches   = 0;
      requests     = 0;
      primes_seen  = 0;
      lists_closed = 0;
    endfunction

    static function bit trial_divide(longint unsigned n);
      longint unsigned d;
      if (n < tdpf_pkg::FIRST_DIVISOR) return 1'b0;
      for (d = tdpf_pkg::FIRST_DIVISOR; d * d <= n; d++) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(value_t value, logic last);
      prime_verdict_t verdict;
      logic [VALUE_BITS-1:0] low;
      low = value[VALUE_BITS-1:0];
      verdict.value    = tdpf_pkg::DATA_W'($signed(low));
      // A set top bit means a negative value, which is never prime.
      verdict.is_prime = !low[VALUE_BITS-1] && trial_divide(longint'(low));
      if (verdict.is_prime && list_primes != tdpf_pkg::COUNT_MAX) list_primes++;
      verdict.prime_count = list_primes;
      verdict.end_of_list = last;
      if (last) begin
        list_primes = '0;
        lists_closed++;
      end
      if (verdict.is_prime) primes_seen++;
      requests++;
      owed_q.push_back(verdict);
    endfunction

    function void check_result(value_t value, logic is_prime, count_t prime_count,
                               logic end_of_list);
      prime_verdict_t exp;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result value=%0d is_prime=%0b count=%0d eol=%0b",
                 $time, value, is_prime, prime_count, end_of_list);
        mismatches++;
        return;
      end
      exp = owed_q.pop_front();
      if (value !== exp.value) begin
        $display("%0t: value_out expected %0d actual %0d", $time, exp.value, value);
        mismatches++;
      end
      if (is_prime !== exp.is_prime) begin
        $display("%0t: is_prime for %0d expected %0b actual %0b",
                 $time, exp.value, exp.is_prime, is_prime);
        mismatches++;
      end
      if (prime_count !== exp.prime_count) begin
        $display("%0t: prime_count for %0d expected %0d actual %0d",
                 $time, exp.value, exp.prime_count, prime_count);
        mismatches++;
      end
      if (end_of_list !== exp.end_of_list) begin
        $display("%0t: end_of_list for %0d expected %0b actual %0b",
                 $time, exp.value, exp.end_of_list, end_of_list);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tdpf_in_if  in_chan ();
  tdpf_out_if out_chan ();

  trial_division_prime_filter_core #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  prime_tally_board tally = new();

  bit steady_flow     = 1'b0;
  int hold_off_cycles = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic int draw_gap();
    return steady_flow ? 0 : $urandom_range(0, 7);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      tally.note_request(in_chan.value, in_chan.last_of_list);
    if (rst_n && out_chan.valid && out_chan.ready)
      tally.check_result(out_chan.value_out, out_chan.is_prime, out_chan.prime_count,
                         out_chan.end_of_list);
  end

  task automatic send_value(value_t value, logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.value        <= value;
    in_chan.last_of_list <= last;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // The monitor notes the last request at the same edge, so look only from the next one.
  task automatic wait_drained();
    @(posedge clk);
    while (tally.owed_q.size() != 0) @(posedge clk);
  endtask

  function automatic value_t pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return value_t'($urandom_range(0, 3000));
    if (r < 70) return value_t'($urandom_range(2, 60) * $urandom_range(2, 60));
    if (r < 85) return value_t'($urandom | 32'h8000_0000);
    if (r < 92) return value_t'($urandom_range(0, 3));
    return value_t'($urandom_range(3001, 100000));
  endfunction

  task automatic send_random_lists(int count);
    int len;
    int i;
    while (count > 0) begin
      len = ($urandom_range(0, 9) == 0) ? 30 : $urandom_range(1, 10);
      if (len > count) len = count;
      for (i = 0; i < len; i++) send_value(pick_value(), i == len - 1);
      count -= len;
    end
  endtask

  // Receiver: random stalls per result, plus a long hold-off on request.
  initial begin
    int gap;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  initial begin
    int blk;
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.value        <= '0;
    in_chan.last_of_list <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Values below two, the smallest primes, squares of primes and both extremes.
    send_value(0, 1'b0);
    send_value(1, 1'b0);
    send_value(2, 1'b0);
    send_value(3, 1'b0);
    send_value(4, 1'b1);
    send_value(-1, 1'b0);
    send_value(-2, 1'b0);
    send_value(value_t'(32'h8000_0000), 1'b0);
    send_value(5, 1'b1);
    send_value(7, 1'b1);
    send_value(9, 1'b0);
    send_value(25, 1'b0);
    send_value(49, 1'b0);
    send_value(97, 1'b0);
    send_value(121, 1'b0);
    send_value(7919, 1'b0);
    send_value(65521, 1'b0);
    send_value(65536, 1'b1);
    send_value(999999, 1'b0);
    send_value(1000003, 1'b0);
    send_value(-7, 1'b1);
    send_value(value_t'(32'h7FFF_FFFF), 1'b1);

    // Sender pauses until the block has handed back every result.
    in_chan.valid <= 1'b0;
    wait_drained();

    // Receiver holds off while fast requests keep coming, so the input stalls.
    steady_flow     = 1'b1;
    hold_off_cycles = LONG_HOLD;
    for (int k = 0; k < 12; k++) send_value(value_t'($urandom_range(0, 40)), k == 11);
    steady_flow = 1'b0;

    for (blk = 0; blk < 4; blk++) begin
      steady_flow = (blk == 1);
      send_random_lists(RAND_ITEMS / 4);
      if (blk == 1) begin
        in_chan.valid <= 1'b0;
        wait_drained();
      end
    end
    steady_flow = 1'b0;
    in_chan.valid <= 1'b0;

    wait_drained();
    repeat (50) @(posedge clk);
    if (tally.owed_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tally.owed_q.size());
      tally.mismatches++;
    end

    $display("Checked %0d requests over %0d closed lists; %0d values were prime.",
             tally.requests, tally.lists_closed, tally.primes_seen);
    $display("Both channels saw random and steady flow, a long output hold-off and drains.");
    if (tally.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("%0t: timeout with %0d results outstanding", $time, tally.owed_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tdpf_pkg.sv
src/tdpf_if.sv
src/trial_division_prime_filter_core.sv
bench/tb_top.sv
